>>> design/detection_filter_frame_transform_assert.svh
// Assertion macros used by the checker file dfft_checker.
`ifndef DETECTION_FILTER_FRAME_TRANSFORM_ASSERT_SVH
`define DETECTION_FILTER_FRAME_TRANSFORM_ASSERT_SVH

// Implication checked on every edge outside reset.
`define DFFT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the next cycle.
`define DFFT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/dfft_pkg.sv
// ----------------------------------------------------------------------------
// dfft_pkg
// Shared types, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package dfft_pkg;

  localparam int NumClassesDef = 8;
  localparam int CordicStagesDef = 16;
  localparam int TableLen = 24;
  localparam int AlongMax = 307;
  localparam logic signed [33:0] CordicX0 = 34'sd652032874;

  localparam logic [2:0] RegMaxRange = 3'd0;
  localparam logic [2:0] RegMirror = 3'd1;
  localparam logic [2:0] RegFrame = 3'd2;
  localparam logic [2:0] RegOffX = 3'd3;
  localparam logic [2:0] RegOffY = 3'd4;
  localparam logic [2:0] RegMask = 3'd5;
  localparam logic [2:0] RegThr = 3'd6;

  localparam logic [1:0] FrameMap = 2'd0;
  localparam logic [1:0] FrameBase = 2'd1;

  typedef enum logic {OP_DET = 1'b0, OP_POSE = 1'b1} op_t;

  // One item in the queue between the front and back parts.
  typedef struct packed {
    logic        is_pose;
    logic [19:0] range;
    logic [15:0] angle;
    logic [8:0]  along;
    logic [18:0] across;
    logic [23:0] pose_x;
    logic [23:0] pose_y;
  } item_t;

  function automatic logic signed [33:0] atan_entry(input int i);
    logic signed [33:0] r;
    case (i)
      0: r = 34'sd536870912;  1: r = 34'sd316933406;
      2: r = 34'sd167458907;  3: r = 34'sd85004756;
      4: r = 34'sd42667331;   5: r = 34'sd21354465;
      6: r = 34'sd10679838;   7: r = 34'sd5340245;
      8: r = 34'sd2670163;    9: r = 34'sd1335087;
      10: r = 34'sd667544;    11: r = 34'sd333772;
      12: r = 34'sd166886;    13: r = 34'sd83443;
      14: r = 34'sd41722;     15: r = 34'sd20861;
      16: r = 34'sd10430;     17: r = 34'sd5215;
      18: r = 34'sd2608;      19: r = 34'sd1304;
      20: r = 34'sd652;       21: r = 34'sd326;
      22: r = 34'sd163;       23: r = 34'sd81;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    logic signed [23:0] r;
    if (v > 48'sd8388607) r = 24'sd8388607;
    else if (v < -48'sd8388608) r = -24'sd8388608;
    else r = v[23:0];
    return r;
  endfunction

endpackage

>>> design/dfft_front.sv
// ----------------------------------------------------------------------------
// dfft_front
// Accepts requests, filters detections and forms queue entries.
// ----------------------------------------------------------------------------
module dfft_front #(
  parameter int NUM_CLASSES = dfft_pkg::NumClassesDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic [7:0]         class_id,
  input  logic [7:0]         score,
  input  logic [19:0]        range,
  input  logic signed [15:0] bearing,
  input  logic signed [19:0] object_width,
  input  logic signed [19:0] object_height,
  input  logic signed [23:0] pose_x,
  input  logic signed [23:0] pose_y,
  input  logic signed [15:0] pose_yaw,
  input  logic [19:0]        max_range,
  input  logic               mirror_bearing,
  input  logic [7:0]         class_present_mask,
  input  logic [63:0]        class_thresholds,
  output logic               q_valid,
  input  logic               q_ready,
  output dfft_pkg::item_t    q_item
);

  localparam int Depth = 2;

  dfft_pkg::item_t mem [Depth];
  logic [0:0] wr_ptr;
  logic [0:0] rd_ptr;
  logic [1:0] count;
  logic       keep;
  logic       push;
  logic       pop;
  logic [7:0] thr;
  dfft_pkg::item_t item;

  always_comb begin
    thr = class_thresholds[{class_id[2:0], 3'b000} +: 8];
    keep = (range <= max_range) && (class_id < 8'(NUM_CLASSES))
      && class_present_mask[class_id[2:0]] && (score >= thr)
      && !object_width[19] && !object_height[19];
    item.is_pose = (op == dfft_pkg::OP_POSE);
    item.range = range;
    item.angle = item.is_pose ? pose_yaw : (mirror_bearing ? bearing : -bearing);
    item.along = (object_width < 20'sd307) ? object_width[8:0] : 9'd307;
    item.across = object_width[18:0];
    item.pose_x = pose_x;
    item.pose_y = pose_y;
  end

  assign in_ready = (count != 2'd2);
  assign push = in_valid && in_ready && (item.is_pose || keep);
  assign q_valid = (count != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> design/dfft_back.sv
// ----------------------------------------------------------------------------
// dfft_back
// Pipelined CORDIC, polar conversion and pose transform with output stage.
// ----------------------------------------------------------------------------
module dfft_back #(
  parameter int CORDIC_STAGES = dfft_pkg::CordicStagesDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_ready,
  input  dfft_pkg::item_t    q_item,
  input  logic [1:0]         target_frame,
  input  logic signed [19:0] sensor_offset_x,
  input  logic signed [19:0] sensor_offset_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] center_x,
  output logic signed [23:0] center_y,
  output logic [8:0]         size_along,
  output logic [18:0]        size_across,
  output logic               frame_invalid
);

  localparam int NS = CORDIC_STAGES + 4;

  // Stage registers: CORDIC stages 0..CORDIC_STAGES, then three math stages.
  logic               v   [NS];
  dfft_pkg::item_t    it  [NS];
  logic               ng  [CORDIC_STAGES+1];
  logic signed [33:0] cx  [CORDIC_STAGES+1];
  logic signed [33:0] cy  [CORDIC_STAGES+1];
  logic signed [33:0] cz  [CORDIC_STAGES+1];

  logic signed [15:0] cosv, sinv;
  logic signed [15:0] pcos, psin;
  logic signed [36:0] px_r, py_r;
  logic signed [21:0] rx, ry;
  logic signed [21:0] rx3, ry3;
  logic signed [37:0] m_xc, m_ys, m_xs, m_yc;
  logic signed [23:0] robot_x, robot_y;
  logic signed [15:0] hcos, hsin;
  logic               adv;
  logic               ov;

  // Whole pipeline moves when the output register can take a value.
  assign adv = !ov || out_ready;
  assign q_ready = adv;

  logic signed [16:0] a0;
  logic               n0;
  always_comb begin
    a0 = 17'(signed'(q_item.angle));
    n0 = 1'b0;
    if (a0 > 17'sd16384) begin
      a0 = a0 - 17'sd32768; n0 = 1'b1;
    end else if (a0 < -17'sd16384) begin
      a0 = a0 + 17'sd32768; n0 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it[0] <= q_item;
      ng[0] <= n0;
      cx[0] <= dfft_pkg::CordicX0;
      cy[0] <= '0;
      cz[0] <= 34'(a0) <<< 16;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (adv) begin
        it[i+1] <= it[i];
        ng[i+1] <= ng[i];
        if (!cz[i][33]) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - dfft_pkg::atan_entry(i);
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + dfft_pkg::atan_entry(i);
        end
      end
    end
  end

  // Round to Q1.14, undo the fold and clamp.
  function automatic logic signed [15:0] fin(input logic signed [33:0] a, input logic n);
    logic signed [33:0] t;
    t = (a + 34'sd32768) >>> 16;
    if (n) t = -t;
    if (t > 34'sd16384) t = 34'sd16384;
    if (t < -34'sd16384) t = -34'sd16384;
    return t[15:0];
  endfunction

  always_comb begin
    cosv = fin(cx[CORDIC_STAGES], ng[CORDIC_STAGES]);
    sinv = fin(cy[CORDIC_STAGES], ng[CORDIC_STAGES]);
  end

  localparam int S0 = CORDIC_STAGES;

  // Polar conversion products; a pose's heading is carried one stage on.
  always_ff @(posedge clk) begin
    if (adv) begin
      it[S0+1] <= it[S0];
      px_r <= $signed({1'b0, it[S0].range}) * cosv + ($signed(37'(it[S0].along)) <<< 13);
      py_r <= $signed({1'b0, it[S0].range}) * sinv;
      pcos <= cosv;
      psin <= sinv;
    end
  end

  // A pose takes effect at the stage where the request right behind it first
  // reads the pose, so requests ahead of it still see the old one.
  always_ff @(posedge clk) begin
    if (rst) begin
      robot_x <= '0;
      robot_y <= '0;
      hcos <= 16'sd16384;
      hsin <= '0;
    end else if (adv) begin
      if (v[S0+1] && it[S0+1].is_pose) begin
        hcos <= pcos;
        hsin <= psin;
      end
      if (v[S0+3] && it[S0+3].is_pose) begin
        robot_x <= it[S0+3].pose_x;
        robot_y <= it[S0+3].pose_y;
      end
    end
  end

  // Round and add sensor offset.
  always_ff @(posedge clk) begin
    if (adv) begin
      it[S0+2] <= it[S0+1];
      rx <= 22'((px_r + 37'sd8192) >>> 14) + 22'(sensor_offset_x);
      ry <= 22'((py_r + 37'sd8192) >>> 14) + 22'(sensor_offset_y);
    end
  end

  // Rotation products; rx/ry travel alongside for the robot base frame.
  always_ff @(posedge clk) begin
    if (adv) begin
      it[S0+3] <= it[S0+2];
      m_xc <= rx * hcos;
      m_ys <= ry * hsin;
      m_xs <= rx * hsin;
      m_yc <= ry * hcos;
      rx3 <= rx;
      ry3 <= ry;
    end
  end

  logic signed [47:0] fx, fy;
  always_comb begin
    case (target_frame)
      dfft_pkg::FrameMap: begin
        fx = 48'((48'(m_xc) - 48'(m_ys) + 48'sd8192) >>> 14) + 48'(robot_x);
        fy = 48'((48'(m_xs) + 48'(m_yc) + 48'sd8192) >>> 14) + 48'(robot_y);
      end
      dfft_pkg::FrameBase: begin
        fx = 48'(rx3);
        fy = 48'(ry3);
      end
      default: begin
        fx = '0;
        fy = '0;
      end
    endcase
  end

  // Valid bits, pose items never reach the output.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NS; k++) v[k] <= 1'b0;
      ov <= 1'b0;
    end else if (adv) begin
      v[0] <= q_valid;
      for (int k = 1; k < NS; k++) v[k] <= v[k-1];
      ov <= v[S0+3] && !it[S0+3].is_pose;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      center_x <= dfft_pkg::sat24(fx);
      center_y <= dfft_pkg::sat24(fy);
      size_along <= it[S0+3].along;
      size_across <= it[S0+3].across;
      frame_invalid <= (target_frame != dfft_pkg::FrameMap)
        && (target_frame != dfft_pkg::FrameBase);
    end
  end

  assign out_valid = ov;

endmodule

>>> design/detection_filter_frame_transform.sv
// ----------------------------------------------------------------------------
// detection_filter_frame_transform
// Detection filter and polar to map or robot base frame transform.
// ----------------------------------------------------------------------------
//  channel | direction | handshake
//  in      | input     | in_valid / in_ready
//  out     | output    | out_valid / out_ready
//  apb     | config    | psel / penable / pwrite, pready tied high
//
// One request per cycle is taken while the queue is not full; a detection
// then passes the queue, the unrolled CORDIC, the two multiplier stages
// and the output register. Pose requests update the heading in order with
// detections. A stalled output holds the whole back pipeline; a two-entry
// queue lets the front keep filtering until it fills. Reset is synchronous.
module detection_filter_frame_transform #(
  parameter int NUM_CLASSES = dfft_pkg::NumClassesDef,
  parameter int CORDIC_STAGES = dfft_pkg::CordicStagesDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic [7:0]         class_id,
  input  logic [7:0]         score,
  input  logic [19:0]        range,
  input  logic signed [15:0] bearing,
  input  logic signed [19:0] object_width,
  input  logic signed [19:0] object_height,
  input  logic signed [23:0] pose_x,
  input  logic signed [23:0] pose_y,
  input  logic signed [15:0] pose_yaw,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] center_x,
  output logic signed [23:0] center_y,
  output logic [8:0]         size_along,
  output logic [18:0]        size_across,
  output logic               frame_invalid,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  logic [19:0]        max_range;
  logic               mirror_bearing;
  logic [1:0]         target_frame;
  logic signed [19:0] sensor_offset_x;
  logic signed [19:0] sensor_offset_y;
  logic [7:0]         class_present_mask;
  logic [63:0]        class_thresholds;
  logic               q_valid, q_ready;
  dfft_pkg::item_t    q_item;
  logic [2:0]         idx;

  assign pready = 1'b1;
  assign idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      max_range <= 20'hFFFFF;
      mirror_bearing <= 1'b0;
      target_frame <= '0;
      sensor_offset_x <= '0;
      sensor_offset_y <= '0;
      class_present_mask <= '0;
      class_thresholds <= '0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        dfft_pkg::RegMaxRange: max_range <= pwdata[19:0];
        dfft_pkg::RegMirror: mirror_bearing <= pwdata[0];
        dfft_pkg::RegFrame: target_frame <= pwdata[1:0];
        dfft_pkg::RegOffX: sensor_offset_x <= pwdata[19:0];
        dfft_pkg::RegOffY: sensor_offset_y <= pwdata[19:0];
        dfft_pkg::RegMask: class_present_mask <= pwdata[7:0];
        dfft_pkg::RegThr: class_thresholds <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      dfft_pkg::RegMaxRange: prdata = 64'(max_range);
      dfft_pkg::RegMirror: prdata = 64'(mirror_bearing);
      dfft_pkg::RegFrame: prdata = 64'(target_frame);
      dfft_pkg::RegOffX: prdata = 64'($unsigned(sensor_offset_x));
      dfft_pkg::RegOffY: prdata = 64'($unsigned(sensor_offset_y));
      dfft_pkg::RegMask: prdata = 64'(class_present_mask);
      dfft_pkg::RegThr: prdata = class_thresholds;
      default: prdata = '0;
    endcase
  end

  dfft_front #(.NUM_CLASSES(NUM_CLASSES)) u_front (
    .clk, .rst, .in_valid, .in_ready, .op, .class_id, .score, .range, .bearing,
    .object_width, .object_height, .pose_x, .pose_y, .pose_yaw, .max_range,
    .mirror_bearing, .class_present_mask, .class_thresholds,
    .q_valid, .q_ready, .q_item
  );

  dfft_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_item, .target_frame, .sensor_offset_x,
    .sensor_offset_y, .out_valid, .out_ready, .center_x, .center_y,
    .size_along, .size_across, .frame_invalid
  );

endmodule

>>> design/dfft_checker.sv
// ----------------------------------------------------------------------------
// dfft_checker
// Port-level checks on the result channel and the register port's ready.
// ----------------------------------------------------------------------------
`include "detection_filter_frame_transform_assert.svh"

module dfft_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [8:0]  size_along,
  input logic        frame_invalid,
  input logic signed [23:0] center_x,
  input logic        pready
);

  `DFFT_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid)
  `DFFT_ASSERT_IMP(a_along, clk, rst, out_valid, size_along <= 9'd307)
  `DFFT_ASSERT_IMP(a_zero, clk, rst, out_valid && frame_invalid, center_x == 24'sd0)
  `DFFT_ASSERT_IMP(a_rdy, clk, rst, 1'b1, pready)

endmodule

bind detection_filter_frame_transform dfft_checker u_chk (
  .clk, .rst, .out_valid, .out_ready, .size_along, .frame_invalid, .center_x,
  .pready
);

>>> dv/detection_filter_frame_transform_checker.sv
// ----------------------------------------------------------------------------
// Detection filter checker
// Watches the request, result and register ports of the block, keeps its
// own copy of the registers and the robot pose, predicts every box and
// compares each result with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module detection_filter_frame_transform_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               op,
  input  logic [7:0]         class_id,
  input  logic [7:0]         score,
  input  logic [19:0]        range,
  input  logic signed [15:0] bearing,
  input  logic signed [19:0] object_width,
  input  logic signed [19:0] object_height,
  input  logic signed [23:0] pose_x,
  input  logic signed [23:0] pose_y,
  input  logic signed [15:0] pose_yaw,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [23:0] center_x,
  input  logic signed [23:0] center_y,
  input  logic [8:0]         size_along,
  input  logic [18:0]        size_across,
  input  logic               frame_invalid,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output int                 errors,
  output int                 pending
);

  localparam int Stages = dfft_pkg::CordicStagesDef;
  localparam longint AtanTab [dfft_pkg::TableLen] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81};

  typedef struct {
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic [8:0]         along;
    logic [18:0]        across;
    logic               inv;
  } box_t;

  box_t box_q[$];

  logic [19:0]        max_rng;
  logic               mirror;
  logic [1:0]         frame_sel;
  logic signed [19:0] off_x, off_y;
  logic [7:0]         cls_mask;
  logic [63:0]        cls_thr;
  longint             rob_x, rob_y, hcos, hsin;

  function automatic void heading_terms(input longint ang, output longint c,
                                        output longint s);
    longint x, y, z, dx, dy;
    bit     neg;
    x = 652032874;
    y = 0;
    neg = 0;
    if (ang > 16384) begin
      ang -= 32768;
      neg = 1;
    end else if (ang < -16384) begin
      ang += 32768;
      neg = 1;
    end
    z = ang * 65536;
    for (int i = 0; i < Stages; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= AtanTab[i];
      end else begin
        x += dx; y -= dy; z += AtanTab[i];
      end
    end
    x = (x + 32768) >>> 16;
    y = (y + 32768) >>> 16;
    if (neg) begin
      x = -x; y = -y;
    end
    if (x > 16384) x = 16384;
    if (x < -16384) x = -16384;
    if (y > 16384) y = 16384;
    if (y < -16384) y = -16384;
    c = x;
    s = y;
  endfunction

  function automatic longint rnd14(input longint v);
    return (v + 8192) >>> 14;
  endfunction

  function automatic logic signed [23:0] clip24(input longint v);
    if (v > 8388607) return 24'sd8388607;
    if (v < -8388608) return -24'sd8388608;
    return v[23:0];
  endfunction

  // Returns 1 and the predicted box when the detection passes the filter.
  function automatic bit predict_box(output box_t b);
    longint             along, c, s, px, py, rx, ry, cx, cy;
    logic signed [15:0] ang;
    logic [7:0]         thr;
    b = '{default: '0};
    if (range > max_rng) return 0;
    if (class_id >= dfft_pkg::NumClassesDef) return 0;
    if (!cls_mask[class_id[2:0]]) return 0;
    thr = cls_thr[class_id[2:0]*8 +: 8];
    if (score < thr) return 0;
    if (object_width < 0 || object_height < 0) return 0;
    along = (object_width < dfft_pkg::AlongMax) ? object_width : dfft_pkg::AlongMax;
    // Negating the half-turn bearing wraps back to the same angle.
    ang = mirror ? bearing : -bearing;
    heading_terms(ang, c, s);
    px = rnd14(longint'(range) * c + along * 8192);
    py = rnd14(longint'(range) * s);
    rx = px + off_x;
    ry = py + off_y;
    if (frame_sel == dfft_pkg::FrameMap) begin
      cx = rnd14(rx * hcos - ry * hsin) + rob_x;
      cy = rnd14(rx * hsin + ry * hcos) + rob_y;
    end else if (frame_sel == dfft_pkg::FrameBase) begin
      cx = rx;
      cy = ry;
    end else begin
      cx = 0;
      cy = 0;
      b.inv = 1'b1;
    end
    b.cx = clip24(cx);
    b.cy = clip24(cy);
    b.along = along[8:0];
    b.across = object_width[18:0];
    return 1;
  endfunction

  always @(posedge clk) begin
    box_t b, e;
    if (rst) begin
      max_rng <= 20'hFFFFF;
      mirror <= 1'b0;
      frame_sel <= dfft_pkg::FrameMap;
      off_x <= '0;
      off_y <= '0;
      cls_mask <= '0;
      cls_thr <= '0;
      rob_x <= 0;
      rob_y <= 0;
      hcos <= 16384;
      hsin <= 0;
      box_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          dfft_pkg::RegMaxRange: max_rng <= pwdata[19:0];
          dfft_pkg::RegMirror: mirror <= pwdata[0];
          dfft_pkg::RegFrame: frame_sel <= pwdata[1:0];
          dfft_pkg::RegOffX: off_x <= pwdata[19:0];
          dfft_pkg::RegOffY: off_y <= pwdata[19:0];
          dfft_pkg::RegMask: cls_mask <= pwdata[7:0];
          dfft_pkg::RegThr: cls_thr <= pwdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (op == dfft_pkg::OP_POSE) begin
          longint c, s;
          heading_terms(pose_yaw, c, s);
          rob_x <= pose_x;
          rob_y <= pose_y;
          hcos <= c;
          hsin <= s;
        end else if (predict_box(b)) begin
          box_q.insert(box_q.size(), b);
        end
      end
      if (out_valid && out_ready) begin
        if (box_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected box, expected none, actual cx=%0d cy=%0d",
                   $time, center_x, center_y);
        end else begin
          e = box_q.pop_front();
          if (center_x !== e.cx || center_y !== e.cy || size_along !== e.along ||
              size_across !== e.across || frame_invalid !== e.inv) begin
            errors++;
            $display("%0t: box mismatch expected cx=%0d cy=%0d along=%0d across=%0d inv=%0d",
                     $time, e.cx, e.cy, e.along, e.across, e.inv);
            $display("%0t:              actual   cx=%0d cy=%0d along=%0d across=%0d inv=%0d",
                     $time, center_x, center_y, size_along, size_across, frame_invalid);
          end
        end
      end
    end
    pending = box_q.size();
  end

  initial begin
    errors = 0;
    pending = 0;
  end

endmodule

>>> dv/detection_filter_frame_transform_test.sv
// ----------------------------------------------------------------------------
// Detection filter testbench
// Writes the registers in several settings, sends directed and random pose
// and detection requests under varied idling, and reports the verdict.
// ----------------------------------------------------------------------------
module detection_filter_frame_transform_test;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 60;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               op = 1'b0;
  logic [7:0]         class_id = '0;
  logic [7:0]         score = '0;
  logic [19:0]        range = '0;
  logic signed [15:0] bearing = '0;
  logic signed [19:0] object_width = '0;
  logic signed [19:0] object_height = '0;
  logic signed [23:0] pose_x = '0;
  logic signed [23:0] pose_y = '0;
  logic signed [15:0] pose_yaw = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [23:0] center_x, center_y;
  logic [8:0]         size_along;
  logic [18:0]        size_across;
  logic               frame_invalid;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [5:0]         paddr = '0;
  logic [63:0]        pwdata = '0;
  logic [63:0]        prdata;
  logic               pready;

  int  errors, pending;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_req = 0;
  int  cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  detection_filter_frame_transform u_top (.*);

  detection_filter_frame_transform_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off when requested.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_request(input logic o, input logic [7:0] cls, input logic [7:0] sc,
                              input logic [19:0] rng, input logic [15:0] brg,
                              input logic [19:0] w, input logic [19:0] h,
                              input logic [23:0] px, input logic [23:0] py,
                              input logic [15:0] yaw);
    bit rdy;
    in_valid <= 1'b1;
    op <= o;
    class_id <= cls;
    score <= sc;
    range <= rng;
    bearing <= brg;
    object_width <= w;
    object_height <= h;
    pose_x <= px;
    pose_y <= py;
    pose_yaw <= yaw;
    // Inputs change only at the rising edge, so ready sampled at the falling
    // edge is the value seen at the next rising edge.
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_random;
    logic [19:0] rng, w, h;
    logic [7:0]  cls;
    cls = ($urandom_range(99) < 88) ? 8'($urandom_range(7)) : 8'($urandom);
    case ($urandom_range(3))
      0: rng = 20'($urandom_range(4095));
      1: rng = 20'hFFFFF - 20'($urandom_range(15));
      default: rng = 20'($urandom);
    endcase
    w = ($urandom_range(99) < 50) ? 20'($urandom_range(600)) : 20'($urandom);
    h = 20'($urandom);
    if ($urandom_range(99) < 85) begin
      w[19] = 1'b0;
      h[19] = 1'b0;
    end
    send_request($urandom_range(99) < 12, cls, 8'($urandom), rng, 16'($urandom), w, h,
                 24'($urandom), 24'($urandom), 16'($urandom));
  endtask

  task automatic drain;
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    reg_write(dfft_pkg::RegMaxRange, 64'd500000);
    reg_write(dfft_pkg::RegMirror, 64'd0);
    reg_write(dfft_pkg::RegFrame, {62'd0, dfft_pkg::FrameMap});
    reg_write(dfft_pkg::RegOffX, 64'(20'sd1000));
    reg_write(dfft_pkg::RegOffY, 64'(-20'sd2000));
    reg_write(dfft_pkg::RegMask, 64'h0000_0000_0000_00BF);
    reg_write(dfft_pkg::RegThr, 64'h0000_0000_6400_0000);

    // Directed part.
    send_request(dfft_pkg::OP_DET, 8'd0, 8'd0, 20'd0, 16'sd0, 20'd0, 20'd0, '0, '0, '0);
    send_request(dfft_pkg::OP_DET, 8'd1, 8'd255, 20'd500000, 16'h7FFF, 20'd524287,
                 20'd524287, '0, '0, '0);
    send_request(dfft_pkg::OP_DET, 8'd1, 8'd5, 20'd500001, 16'sd0, 20'd5, 20'd5,
                 '0, '0, '0);
    send_request(dfft_pkg::OP_DET, 8'd1, 8'd5, 20'hFFFFF, 16'sd0, 20'd5, 20'd5,
                 '0, '0, '0);
    send_request(dfft_pkg::OP_DET, 8'd3, 8'd99, 20'd1000, 16'sd100, 20'd50, 20'd50,
                 '0, '0, '0);
    send_request(dfft_pkg::OP_DET, 8'd3, 8'd100, 20'd1000, 16'sd100, 20'd50, 20'd50,
                 '0, '0, '0);
    send_request(dfft_pkg::OP_DET, 8'd6, 8'd200, 20'd1000, 16'sd100, 20'd50, 20'd50,
                 '0, '0, '0);
    send_request(dfft_pkg::OP_DET, 8'd8, 8'd200, 20'd1000, 16'sd100, 20'd50, 20'd50,
                 '0, '0, '0);
    send_request(dfft_pkg::OP_DET, 8'd255, 8'd200, 20'd1000, 16'sd100, 20'd50, 20'd50,
                 '0, '0, '0);
    send_request(dfft_pkg::OP_DET, 8'd2, 8'd9, 20'd1000, 16'sd100, -20'sd1, 20'd50,
                 '0, '0, '0);
    send_request(dfft_pkg::OP_DET, 8'd2, 8'd9, 20'd1000, 16'sd100, 20'd50, -20'sd524288,
                 '0, '0, '0);
    send_request(dfft_pkg::OP_DET, 8'd2, 8'd9, 20'd40000, 16'h8000, 20'd306, 20'd1,
                 '0, '0, '0);
    send_request(dfft_pkg::OP_DET, 8'd2, 8'd9, 20'd40000, 16'sd16384, 20'd307, 20'd1,
                 '0, '0, '0);
    send_request(dfft_pkg::OP_DET, 8'd2, 8'd9, 20'd40000, -16'sd16384, 20'd308, 20'd1,
                 '0, '0, '0);
    send_request(dfft_pkg::OP_POSE, 8'hFF, 8'hFF, 20'hFFFFF, 16'hFFFF, 20'hFFFFF, 20'hFFFFF,
                 24'sd8388607, -24'sd8388608, 16'h7FFF);
    send_request(dfft_pkg::OP_DET, 8'd4, 8'd9, 20'd500000, 16'sd0, 20'd100, 20'd1,
                 '0, '0, '0);
    send_request(dfft_pkg::OP_POSE, '0, '0, '0, '0, '0, '0, -24'sd8388608, 24'sd8388607,
                 16'h8000);
    send_request(dfft_pkg::OP_DET, 8'd5, 8'd9, 20'd500000, 16'sd0, 20'd100, 20'd1,
                 '0, '0, '0);
    send_request(dfft_pkg::OP_POSE, '0, '0, '0, '0, '0, '0, 24'sd1234, -24'sd4321,
                 16'sd16385);
    send_request(dfft_pkg::OP_DET, 8'd7, 8'd9, 20'd300000, 16'sd9000, 20'd100, 20'd1,
                 '0, '0, '0);
    send_request(dfft_pkg::OP_POSE, '0, '0, '0, '0, '0, '0, 24'sd0, 24'sd0, -16'sd16385);
    send_request(dfft_pkg::OP_DET, 8'd0, 8'd9, 20'd300000, -16'sd9000, 20'd100, 20'd1,
                 '0, '0, '0);
    in_valid <= 1'b0;
    drain();

    // Random part: six register settings, idling rotated between them.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 81; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 81; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      case (ph)
        0: reg_write(dfft_pkg::RegMaxRange, 64'hFFFFF);
        1: reg_write(dfft_pkg::RegMaxRange, 64'd0);
        default: reg_write(dfft_pkg::RegMaxRange,
                           64'($urandom_range(20'hFFFFF, 20'h40000)));
      endcase
      reg_write(dfft_pkg::RegMirror, 64'(ph % 2));
      reg_write(dfft_pkg::RegFrame, 64'(ph % 4));
      reg_write(dfft_pkg::RegOffX, (ph == 2) ? 64'(-20'sd524288) : 64'(20'($urandom)));
      reg_write(dfft_pkg::RegOffY, (ph == 2) ? 64'(20'sd524287) : 64'(20'($urandom)));
      reg_write(dfft_pkg::RegMask,
                (ph == 5) ? 64'h0 : 64'($urandom_range(255, 128) | 8'h7F));
      reg_write(dfft_pkg::RegThr, (ph == 0) ? 64'hFFFF_FFFF_FFFF_FFFF :
                (ph == 3) ? 64'h0 : {$urandom, $urandom} & 64'h7F7F_7F7F_7F7F_7F7F);
      if (ph == 0) hold_req = 1;
      for (int n = 0; n < 205; n++) send_random();
      in_valid <= 1'b0;
      drain();
    end

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/dfft_pkg.sv
design/dfft_front.sv
design/dfft_back.sv
design/detection_filter_frame_transform.sv
design/dfft_checker.sv
dv/detection_filter_frame_transform_checker.sv
dv/detection_filter_frame_transform_test.sv
